// ----- rtl/core/nqtok_pkg.sv -----
// shared types and constants for the n-quads term tokenizer
`timescale 1ns / 1ps

package nqtok_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int HASH_W      = 28;

  localparam logic [1:0] LS_OK      = 2'd0;
  localparam logic [1:0] LS_COMMENT = 2'd1;
  localparam logic [1:0] LS_BAD     = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       term_last;
    logic [2:0] term_index;
    logic       line_done;
    logic [1:0] line_status;
  } tok_res_t;

  // one parsed item: up to two results and the hash for the closing byte
  typedef struct packed {
    logic              two;
    tok_res_t          r0;
    tok_res_t          r1;
    logic [HASH_W-1:0] hash;
  } tok_entry_t;

endpackage

// ----- rtl/core/nquads_term_tokenizer_top.sv -----
// top level of the n-quads term tokenizer
`timescale 1ns / 1ps
// path: the first result of an item passes the queue slot, the middle stage and the
//   output register in that order; a second result of the same item follows it
// throughput: one input byte per cycle unless in_stall; one result per cycle out, set
//   by the output register, unless out_stall; a URI close or a newline with a pending
//   byte yields two results, absorbed by the four-item queue between parser and output stage
// reset: synchronous rst clears parser state, queue pointers and stage valids

module nquads_term_tokenizer_top #(
  parameter int BUCKETS = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       term_last,
  output logic [2:0] term_index,
  output logic [2:0] bucket,
  output logic       line_done,
  output logic [1:0] line_status
);
  import nqtok_pkg::*;

  logic       q_push;
  tok_entry_t q_entry;
  logic       q_full;
  logic       head_valid;
  tok_entry_t head_entry;
  logic       q_pop;

  nqtok_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  nqtok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop)
  );

  nqtok_back #(
    .BUCKETS (BUCKETS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .term_last   (term_last),
    .term_index  (term_index),
    .bucket      (bucket),
    .line_done   (line_done),
    .line_status (line_status)
  );

endmodule

// ----- rtl/core/nqtok_front.sv -----
// byte parser: term mode tracking, byte hold, elf hash and line status
`timescale 1ns / 1ps

module nqtok_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  q_push,
  output nqtok_pkg::tok_entry_t q_entry
);
  import nqtok_pkg::*;

  typedef enum logic [3:0] {
    M_BETWEEN,
    M_URI,
    M_SWALLOW,
    M_BNODE2,
    M_WORD_LEAD,
    M_WORD,
    M_LIT,
    M_ESC,
    M_HEX,
    M_LIT_CLOSE,
    M_DT2,
    M_DT3,
    M_COMMENT,
    M_DONE
  } mode_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UPR_U = 8'h55;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LWR_U = 8'h75;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [HASH_W-1:0] elf_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] c);
    logic [31:0] t;
    logic [3:0]  g;
    t = {h, 4'b0000} + {24'b0, c};
    g = t[31:28];
    return t[HASH_W-1:0] ^ {20'b0, g, 4'b0000};
  endfunction

  mode_t             mode, mode_next;
  logic [3:0]        skip_left, skip_left_next;
  logic [HASH_W-1:0] hash, hash_next;
  logic [7:0]        held_byte, held_byte_next;
  logic              held_valid, held_valid_next;
  logic [2:0]        terms_seen, terms_seen_next;
  logic              line_bad, line_bad_next;
  logic              dot_seen, dot_seen_next;

  logic              accept;
  logic              nl;
  logic              hold_en;
  logic [7:0]        hold_c;
  logic              uri_close;
  logic              push_last;
  logic              do_between;
  logic [HASH_W-1:0] step;
  logic [2:0]        idx;
  logic              held_push;
  logic              second_en;
  logic              cut_term;
  logic [1:0]        status;
  tok_res_t          held_res;
  tok_res_t          second_res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign nl       = (in_byte == CH_NL);
  assign idx      = terms_seen - 3'd1;

  always_comb begin
    mode_next       = mode;
    skip_left_next  = skip_left;
    hash_next       = hash;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    terms_seen_next = terms_seen;
    line_bad_next   = line_bad;
    dot_seen_next   = dot_seen;
    hold_en         = 1'b0;
    hold_c          = in_byte;
    uri_close       = 1'b0;
    push_last       = 1'b0;
    do_between      = 1'b0;

    if (!nl) begin
      case (mode)
        M_BETWEEN: begin
          do_between = 1'b1;
        end
        M_URI: begin
          if (in_byte == CH_GT) begin
            uri_close = 1'b1;
            mode_next = M_SWALLOW;
          end else if (!is_ws(in_byte)) begin
            hold_en = 1'b1;
          end
        end
        M_SWALLOW: begin
          mode_next = M_BETWEEN;
        end
        M_BNODE2: begin
          hold_en   = 1'b1;
          hold_c    = CH_COLON;
          mode_next = M_WORD_LEAD;
        end
        M_WORD_LEAD: begin
          if (!is_ws(in_byte)) begin
            hold_en   = 1'b1;
            mode_next = M_WORD;
          end
        end
        M_WORD: begin
          if (is_ws(in_byte)) begin
            push_last = 1'b1;
            mode_next = M_BETWEEN;
          end else begin
            hold_en = 1'b1;
          end
        end
        M_LIT: begin
          if (in_byte == CH_QUOTE) begin
            hold_en   = 1'b1;
            mode_next = M_LIT_CLOSE;
          end else if (in_byte == CH_BSL) begin
            mode_next = M_ESC;
          end else if (in_byte != CH_SP) begin
            hold_en = 1'b1;
          end
        end
        M_ESC: begin
          if (in_byte == CH_LWR_U) begin
            skip_left_next = 4'd4;
            mode_next      = M_HEX;
          end else if (in_byte == CH_UPR_U) begin
            skip_left_next = 4'd8;
            mode_next      = M_HEX;
          end else begin
            mode_next = M_LIT;
          end
        end
        M_HEX: begin
          if (skip_left > 4'd1) begin
            skip_left_next = skip_left - 4'd1;
          end else begin
            skip_left_next = 4'd0;
            mode_next      = M_LIT;
          end
        end
        M_LIT_CLOSE: begin
          if (in_byte == CH_AT) begin
            hold_en   = 1'b1;
            mode_next = M_WORD_LEAD;
          end else if (in_byte == CH_CARET) begin
            hold_en   = 1'b1;
            mode_next = M_DT2;
          end else begin
            push_last  = 1'b1;
            mode_next  = M_BETWEEN;
            do_between = 1'b1;
          end
        end
        M_DT2: begin
          hold_en   = 1'b1;
          mode_next = M_DT3;
        end
        M_DT3: begin
          hold_en   = 1'b1;
          hold_c    = CH_LT;
          mode_next = M_URI;
        end
        default: begin
        end
      endcase
    end

    step = elf_step(hash, uri_close ? CH_GT : hold_c);

    if (hold_en) begin
      held_byte_next  = hold_c;
      held_valid_next = 1'b1;
      hash_next       = step;
    end
    if (uri_close) begin
      held_valid_next = 1'b0;
      hash_next       = step;
    end
    if (push_last) begin
      held_valid_next = 1'b0;
    end

    if (do_between) begin
      if (line_bad) begin
        mode_next = M_DONE;
      end else if (!is_ws(in_byte)) begin
        if (in_byte == CH_HASH && terms_seen == 3'd0) begin
          mode_next = M_COMMENT;
        end else if (in_byte == CH_DOT) begin
          dot_seen_next = 1'b1;
          mode_next     = M_DONE;
        end else if (in_byte == CH_LT || in_byte == CH_US || in_byte == CH_QUOTE) begin
          // new term opens with its initial byte held
          if (terms_seen >= 3'd4) begin
            line_bad_next = 1'b1;
          end
          if (terms_seen < 3'd7) begin
            terms_seen_next = terms_seen + 3'd1;
          end
          hash_next       = {20'b0, in_byte};
          held_byte_next  = in_byte;
          held_valid_next = 1'b1;
          if (in_byte == CH_LT) begin
            mode_next = M_URI;
          end else if (in_byte == CH_US) begin
            mode_next = M_BNODE2;
          end else begin
            mode_next = M_LIT;
          end
        end else begin
          line_bad_next = 1'b1;
          mode_next     = M_DONE;
        end
      end
    end

    // a newline ends the line and restarts from the reset state
    if (nl) begin
      mode_next       = M_BETWEEN;
      skip_left_next  = 4'd0;
      hash_next       = '0;
      held_byte_next  = 8'd0;
      held_valid_next = 1'b0;
      terms_seen_next = 3'd0;
      line_bad_next   = 1'b0;
      dot_seen_next   = 1'b0;
    end
  end

  always_comb begin
    cut_term = (mode == M_URI) || (mode == M_BNODE2) || (mode == M_LIT) ||
               (mode == M_ESC) || (mode == M_HEX) || (mode == M_DT2) || (mode == M_DT3);
    if (mode == M_COMMENT) begin
      status = LS_COMMENT;
    end else if (line_bad || cut_term || !dot_seen) begin
      status = LS_BAD;
    end else begin
      status = LS_OK;
    end

    held_push = held_valid && (hold_en || uri_close || push_last || nl);
    second_en = uri_close || nl;

    held_res.out_byte    = held_byte;
    held_res.term_last   = push_last || nl;
    held_res.term_index  = idx;
    held_res.line_done   = 1'b0;
    held_res.line_status = LS_OK;

    if (nl) begin
      second_res.out_byte    = 8'd0;
      second_res.term_last   = 1'b0;
      second_res.term_index  = 3'd0;
      second_res.line_done   = 1'b1;
      second_res.line_status = status;
    end else begin
      second_res.out_byte    = CH_GT;
      second_res.term_last   = 1'b1;
      second_res.term_index  = idx;
      second_res.line_done   = 1'b0;
      second_res.line_status = LS_OK;
    end

    q_entry.two  = held_push && second_en;
    q_entry.r0   = held_push ? held_res : second_res;
    q_entry.r1   = second_res;
    q_entry.hash = uri_close ? step : hash;
    q_push       = accept && (held_push || second_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_BETWEEN;
      skip_left  <= 4'd0;
      hash       <= '0;
      held_byte  <= 8'd0;
      held_valid <= 1'b0;
      terms_seen <= 3'd0;
      line_bad   <= 1'b0;
      dot_seen   <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      skip_left  <= skip_left_next;
      hash       <= hash_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      terms_seen <= terms_seen_next;
      line_bad   <= line_bad_next;
      dot_seen   <= dot_seen_next;
    end
  end

endmodule

// ----- rtl/core/nqtok_queue.sv -----
// small fifo of parsed items between parser and output stage
`timescale 1ns / 1ps

module nqtok_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  nqtok_pkg::tok_entry_t push_entry,
  output logic                  full,
  output logic                  head_valid,
  output nqtok_pkg::tok_entry_t head_entry,
  input  logic                  pop
);
  import nqtok_pkg::*;

  tok_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/nqtok_back.sv -----
// result sequencing, bucket reduction and output register
`timescale 1ns / 1ps

module nqtok_back #(
  parameter int BUCKETS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  nqtok_pkg::tok_entry_t head_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  term_last,
  output logic [2:0]            term_index,
  output logic [2:0]            bucket,
  output logic                  line_done,
  output logic [1:0]            line_status
);
  import nqtok_pkg::*;

  // quotient estimate is at most one low, so the remainder stays below twice BUCKETS
  localparam logic [31:0] RECIP = 32'(64'd4294967295 / BUCKETS);
  localparam logic [4:0]  BKT5  = 5'(BUCKETS);

  logic        sel;
  logic        take;
  logic        out_adv;
  logic        s1_adv;
  tok_res_t    cur_res;
  logic [59:0] prod;

  logic        s1_valid;
  tok_res_t    s1_res;
  logic [4:0]  s1_q;
  logic [4:0]  s1_x;

  logic [9:0]  qb;
  logic [4:0]  rem;
  logic [4:0]  rem_fix;

  assign out_adv = !out_valid || !out_stall;
  assign s1_adv  = !s1_valid || out_adv;
  assign take    = head_valid && s1_adv;
  assign pop     = take && (!head_entry.two || sel);
  assign cur_res = sel ? head_entry.r1 : head_entry.r0;
  assign prod    = {32'b0, head_entry.hash} * {28'b0, RECIP};

  // only the low five bits of x - q*B matter since the remainder is below 32
  assign qb      = {5'b0, s1_q} * {5'b0, BKT5};
  assign rem     = s1_x - qb[4:0];
  assign rem_fix = (rem >= BKT5) ? (rem - BKT5) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        sel <= head_entry.two && !sel;
      end
      if (s1_adv) begin
        s1_valid <= take;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && take) begin
      s1_res <= cur_res;
      s1_q   <= prod[36:32];
      s1_x   <= head_entry.hash[4:0];
    end
    if (out_adv && s1_valid) begin
      out_byte    <= s1_res.out_byte;
      term_last   <= s1_res.term_last;
      term_index  <= s1_res.term_index;
      bucket      <= s1_res.term_last ? rem_fix[2:0] : 3'd0;
      line_done   <= s1_res.line_done;
      line_status <= s1_res.line_status;
    end
  end

`ifndef SYNTHESIS
  a_bucket_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !term_last |-> bucket == 3'd0)
    else $error("bucket set on a non-final byte");

  a_line_item_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> !term_last && out_byte == 8'd0 && term_index == 3'd0)
    else $error("line status item carries byte fields");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid)
    else $error("middle stage dropped an item under stall");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && term_last && BUCKETS <= 8 |-> int'(bucket) < BUCKETS)
    else $error("bucket out of range");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    sel |-> head_valid && head_entry.two)
    else $error("second result selected without a paired item");
`endif

endmodule
